// ===== sv/ecnp_pkg.sv =====
// ============================================================================
// ecnp_pkg
// Types and constants shared by the projection block.
// ============================================================================
`default_nettype none

package ecnp_pkg;

    localparam int unsigned MaxALenDefault = 32;
    localparam int unsigned MaxQLenDefault = 32;
    localparam int unsigned StoreDepth     = 32;
    localparam int unsigned IdxW           = 5;
    localparam int unsigned CntW           = 6;
    localparam int unsigned ValW           = 33;
    localparam int unsigned SumW           = 40;
    localparam int unsigned QuoW           = 41;

    typedef struct packed {
        logic        which_vector;
        logic [31:0] elem_value;
        logic        last_item;
    } t_in_word;

    typedef struct packed {
        logic        out_vector;
        logic [4:0]  out_index;
        logic [30:0] out_value;
        logic        last_result;
    } t_out_word;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SUMQ,
        S_PIVOT,
        S_PART,
        S_MUL,
        S_DECIDE,
        S_DIV,
        S_EMIT_RD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       init_run;
        logic       sum_step;
        logic       pick_pivot;
        logic       part_step;
        logic       mul_step;
        logic       decide;
        logic       div_start;
        logic       emit_read;
        logic       emit_show;
        logic       clear_run;
    } t_ctrl;

    typedef struct packed {
        logic       sum_done;
        logic       masks_empty;
        logic       part_done;
        logic       div_done;
        logic       emit_done;
        logic       have_items;
    } t_stat;

endpackage

`default_nettype wire

// ===== sv/ecnp_ctrl.sv =====
// ============================================================================
// ecnp_ctrl
// Sequencer for loading, threshold search, division and result output.
// ============================================================================
`default_nettype none

module ecnp_ctrl
    import ecnp_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_in_valid,
    input  wire    i_last,
    input  wire    i_out_busy,
    input  t_stat  i_stat,
    output logic   o_in_stall,
    output t_ctrl  o_ctrl
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid && i_last) begin
                    n_state = S_SUMQ;
                end
            end
            S_SUMQ: begin
                if (i_stat.sum_done) begin
                    n_state = S_PIVOT;
                end
            end
            S_PIVOT: begin
                if (i_stat.masks_empty) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_PART;
                end
            end
            S_PART: begin
                if (i_stat.part_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:    n_state = S_DECIDE;
            S_DECIDE: n_state = S_PIVOT;
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = i_stat.have_items ? S_EMIT_RD : S_LOAD;
                end
            end
            S_EMIT_RD: begin
                if (!i_out_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_state = i_stat.emit_done ? S_LOAD : S_EMIT_RD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_ctrl     = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_LOAD: begin
                o_in_stall    = 1'b0;
                o_ctrl.load   = i_in_valid;
                o_ctrl.init_run = i_in_valid && i_last;
            end
            S_SUMQ:    o_ctrl.sum_step   = 1'b1;
            S_PIVOT: begin
                o_ctrl.pick_pivot = 1'b1;
                o_ctrl.div_start  = i_stat.masks_empty;
            end
            S_PART:    o_ctrl.part_step  = 1'b1;
            S_MUL:     o_ctrl.mul_step   = 1'b1;
            S_DECIDE:  o_ctrl.decide     = 1'b1;
            S_DIV: begin
                o_ctrl.clear_run = i_stat.div_done && !i_stat.have_items;
            end
            S_EMIT_RD: o_ctrl.emit_read  = !i_out_busy;
            S_EMIT: begin
                o_ctrl.emit_show = 1'b1;
                o_ctrl.clear_run = i_stat.emit_done;
            end
            default: ;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> (r_state == S_LOAD))
        else $error("input taken outside load phase");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |=> (r_state == S_PIVOT))
        else $error("decide not followed by pivot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.emit_show |-> $past(o_ctrl.emit_read))
        else $error("emit without read");

endmodule

`default_nettype wire

// ===== sv/ecnp_div.sv =====
// ============================================================================
// ecnp_div
// Restoring divider, one quotient bit per cycle, floor rounding of rho.
// ============================================================================
`default_nettype none

module ecnp_div
    import ecnp_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire  signed [SumW-1:0]     i_num,
    input  wire         [CntW:0]       i_den,
    output logic                       o_done,
    output logic signed [QuoW-1:0]     o_quo
);

    localparam int unsigned StepW = $clog2(SumW + 1);

    logic               r_busy;
    logic [StepW-1:0]   r_step;
    logic [SumW-1:0]    r_mag;
    logic [CntW:0]      r_rem;
    logic [SumW-1:0]    r_q;
    logic               r_neg;
    logic [CntW:0]      r_den;
    logic               r_done;
    logic [CntW+1:0]    w_try;
    logic               w_zero;

    assign w_try  = {r_rem, r_mag[SumW-1]} - {1'b0, r_den};
    assign w_zero = (i_den == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !w_zero;
                r_done <= w_zero;
            end else if (r_busy && r_step == StepW'(SumW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= '0;
            r_neg  <= i_num[SumW-1];
            r_mag  <= i_num[SumW-1] ? (SumW'(0) - i_num) : i_num;
            r_rem  <= '0;
            r_q    <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_step <= r_step + StepW'(1);
            r_mag  <= {r_mag[SumW-2:0], 1'b0};
            if (!w_try[CntW+1]) begin
                r_rem <= w_try[CntW:0];
                r_q   <= {r_q[SumW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[CntW-1:0], r_mag[SumW-1]};
                r_q   <= {r_q[SumW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (r_den == '0) begin
            o_quo = '0;
        end else if (r_neg) begin
            o_quo = -$signed({1'b0, r_q}) - ((r_rem != '0) ? QuoW'(1) : QuoW'(0));
        end else begin
            o_quo = $signed({1'b0, r_q});
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== sv/ecnp_dp.sv =====
// ============================================================================
// ecnp_dp
// Element stores, active masks, partition pass, balance and output stage.
// ============================================================================
`default_nettype none

module ecnp_dp
    import ecnp_pkg::*;
#(
    parameter int unsigned MAX_A_LEN = MaxALenDefault,
    parameter int unsigned MAX_Q_LEN = MaxQLenDefault
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_ctrl      i_ctrl,
    input  t_in_word   i_in,
    input  wire        i_out_stall,
    output t_stat      o_stat,
    output logic       o_out_busy,
    output logic       o_out_valid,
    output t_out_word  o_out
);

    logic signed [ValW-1:0] r_a_mem [StoreDepth];
    logic signed [ValW-1:0] r_q_mem [StoreDepth];

    logic [CntW-1:0]  r_a_cnt, r_q_cnt;
    logic [31:0]      r_a_mask, r_q_mask, r_ga, r_la, r_gq, r_lq;
    logic signed [SumW-1:0] r_sum_a, r_sum_q, r_sum_q_all, r_ds_a, r_ds_q;
    logic [CntW-1:0]  r_tak_a, r_tak_q, r_n_a, r_n_gq;
    logic signed [ValW-1:0] r_piv;
    logic [CntW:0]    r_idx;
    logic signed [SumW-1:0] r_df;
    logic signed [QuoW-1:0] r_rho;
    logic signed [ValW-1:0] r_rd_a, r_rd_q;
    logic             r_out_valid;
    t_out_word        r_out;
    logic             r_emit_q;

    logic [IdxW-1:0]  w_ix;
    logic             w_div_done;
    logic signed [QuoW-1:0] w_quo;
    logic signed [SumW-1:0] w_num;
    logic [CntW:0]    w_den;
    logic [IdxW-1:0]  w_a_first, w_q_first;
    logic signed [ValW-1:0] w_val;
    logic signed [QuoW+1:0] w_res;
    logic             w_a_has;
    logic [CntW:0]    w_cnt;
    logic signed [SumW-1:0] w_prod;

    assign w_ix = r_idx[IdxW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && !i_in.which_vector && r_a_cnt < CntW'(MAX_A_LEN)) begin
            r_a_mem[r_a_cnt[IdxW-1:0]] <= ValW'($signed(i_in.elem_value));
        end
        if (i_ctrl.load && i_in.which_vector && r_q_cnt < CntW'(MAX_Q_LEN)) begin
            r_q_mem[r_q_cnt[IdxW-1:0]] <= -ValW'($signed(i_in.elem_value));
        end
        r_rd_a <= r_a_mem[w_ix];
        r_rd_q <= r_q_mem[w_ix];
    end

    always_comb begin
        w_a_first = '0;
        w_q_first = '0;
        for (int k = StoreDepth - 1; k >= 0; k--) begin
            if (r_a_mask[k]) w_a_first = IdxW'(k);
            if (r_q_mask[k]) w_q_first = IdxW'(k);
        end
    end
    assign w_a_has = (r_a_mask != '0);

    // The partition pass reads one entry of each store per cycle; the data are
    // registered and arrive in the cycle after their index.
    logic [CntW:0] r_pidx;
    logic          r_pvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_cnt <= '0; r_q_cnt <= '0; r_a_mask <= '0; r_q_mask <= '0;
            r_idx <= '0; r_pvalid <= 1'b0; r_out_valid <= 1'b0;
        end else begin
            r_pvalid <= 1'b0;
            if (i_ctrl.load) begin
                if (!i_in.which_vector && r_a_cnt < CntW'(MAX_A_LEN))
                    r_a_cnt <= r_a_cnt + CntW'(1);
                if (i_in.which_vector && r_q_cnt < CntW'(MAX_Q_LEN))
                    r_q_cnt <= r_q_cnt + CntW'(1);
            end
            if (i_ctrl.init_run) begin
                r_idx <= '0;
            end
            if (i_ctrl.sum_step) begin
                r_idx    <= (r_idx == (CntW+1)'(r_q_cnt)) ? '0 : r_idx + 1'b1;
                r_pvalid <= (r_idx < (CntW+1)'(r_q_cnt));
                r_pidx   <= r_idx;
                if (r_idx == (CntW+1)'(r_q_cnt)) begin
                    for (int k = 0; k < 32; k++) begin
                        r_a_mask[k] <= (k < r_a_cnt);
                        r_q_mask[k] <= (k < r_q_cnt);
                    end
                end
            end
            if (i_ctrl.pick_pivot) begin
                r_idx <= '0;
            end
            if (i_ctrl.part_step) begin
                r_idx    <= (r_idx == (CntW+1)'(StoreDepth)) ? '0 : r_idx + 1'b1;
                r_pvalid <= (r_idx < (CntW+1)'(StoreDepth));
                r_pidx   <= r_idx;
            end
            if (i_ctrl.decide) begin
                if (r_df < 0) begin
                    r_a_mask <= r_la; r_q_mask <= r_lq;
                end else begin
                    r_a_mask <= r_ga; r_q_mask <= r_gq;
                end
            end
            if (w_div_done) begin
                r_idx <= '0;
            end
            if (i_ctrl.emit_read) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_ctrl.emit_show && !r_emit_q && r_idx == (CntW+1)'(r_a_cnt)) begin
                r_idx <= '0;
            end
            if (i_ctrl.emit_show) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_ctrl.clear_run) begin
                r_a_cnt <= '0; r_q_cnt <= '0; r_a_mask <= '0; r_q_mask <= '0;
            end
        end
    end

    assign w_cnt  = (CntW+1)'(r_tak_a) + (CntW+1)'(r_n_a) + (CntW+1)'(r_q_cnt)
                  - (CntW+1)'(r_tak_q) - (CntW+1)'(r_n_gq);
    assign w_prod = SumW'($signed({1'b0, w_cnt})) * SumW'(r_piv);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.init_run) begin
            r_sum_q_all <= '0; r_sum_a <= '0; r_sum_q <= '0;
            r_tak_a <= '0; r_tak_q <= '0;
        end
        if (i_ctrl.sum_step && r_pvalid) begin
            r_sum_q_all <= r_sum_q_all + SumW'(r_rd_q);
        end
        if (i_ctrl.pick_pivot) begin
            r_piv <= w_a_has ? r_a_mem[w_a_first] : r_q_mem[w_q_first];
            r_ga <= '0; r_la <= '0; r_gq <= '0; r_lq <= '0;
            r_ds_a <= '0; r_ds_q <= '0; r_n_a <= '0; r_n_gq <= '0;
        end
        if (i_ctrl.part_step && r_pvalid) begin
            if (r_a_mask[r_pidx[IdxW-1:0]]) begin
                if (r_rd_a > r_piv) begin
                    r_ga[r_pidx[IdxW-1:0]] <= 1'b1;
                    r_n_a  <= r_n_a + CntW'(1);
                    r_ds_a <= r_ds_a + SumW'(r_rd_a);
                end else if (r_rd_a < r_piv) begin
                    r_la[r_pidx[IdxW-1:0]] <= 1'b1;
                end else begin
                    r_n_a  <= r_n_a + CntW'(1);
                    r_ds_a <= r_ds_a + SumW'(r_rd_a);
                end
            end
            if (r_q_mask[r_pidx[IdxW-1:0]]) begin
                if (r_rd_q > r_piv) begin
                    r_gq[r_pidx[IdxW-1:0]] <= 1'b1;
                    r_n_gq <= r_n_gq + CntW'(1);
                    r_ds_q <= r_ds_q + SumW'(r_rd_q);
                end else if (r_rd_q < r_piv) begin
                    r_lq[r_pidx[IdxW-1:0]] <= 1'b1;
                end
            end
        end
        if (i_ctrl.mul_step) begin
            r_df <= r_sum_a + r_ds_a + r_sum_q_all - r_sum_q - r_ds_q - w_prod;
        end
        if (i_ctrl.decide && r_df < 0) begin
            r_sum_a <= r_sum_a + r_ds_a; r_tak_a <= r_tak_a + r_n_a;
            r_sum_q <= r_sum_q + r_ds_q; r_tak_q <= r_tak_q + r_n_gq;
        end
        if (w_div_done) begin
            r_rho    <= w_quo;
            r_emit_q <= (r_a_cnt == '0);
        end
        if (i_ctrl.emit_show) begin
            r_out.out_vector  <= r_emit_q;
            r_out.out_index   <= w_ix - IdxW'(1);
            r_out.out_value   <= (w_res <= 0) ? '0
                               : (w_res > (QuoW+2)'(32'h7FFFFFFF)) ? 31'h7FFFFFFF
                               : w_res[30:0];
            r_out.last_result <= o_stat.emit_done;
            if (!r_emit_q && r_idx == (CntW+1)'(r_a_cnt)) begin
                r_emit_q <= 1'b1;
            end
        end
    end

    always_comb begin
        w_val = r_emit_q ? r_rd_q : r_rd_a;
        w_res = r_emit_q ? ((QuoW+2)'(-w_val) + (QuoW+2)'(r_rho))
                         : ((QuoW+2)'(w_val) - (QuoW+2)'(r_rho));
    end

    assign w_num = r_sum_a + r_sum_q_all - r_sum_q;
    assign w_den = (CntW+1)'(r_tak_a) + (CntW+1)'(r_q_cnt) - (CntW+1)'(r_tak_q);

    ecnp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctrl.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign o_stat.sum_done    = i_ctrl.sum_step && (r_idx == (CntW+1)'(r_q_cnt));
    assign o_stat.masks_empty = (r_a_mask == '0) && (r_q_mask == '0);
    assign o_stat.part_done   = i_ctrl.part_step && (r_idx == (CntW+1)'(StoreDepth));
    assign o_stat.div_done    = w_div_done;
    assign o_stat.have_items  = (r_a_cnt != '0) || (r_q_cnt != '0);
    assign o_stat.emit_done   = (r_emit_q || r_q_cnt == '0)
                              && (r_emit_q ? r_idx == (CntW+1)'(r_q_cnt)
                                           : r_idx == (CntW+1)'(r_a_cnt));
    assign o_out_busy  = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_cnt <= CntW'(MAX_A_LEN)) && (r_q_cnt <= CntW'(MAX_Q_LEN)))
        else $error("store count beyond length");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.decide |=> ((r_a_mask & ~$past(r_a_mask)) == '0))
        else $error("active mask grew");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled word dropped");

endmodule

`default_nettype wire

// ===== sv/equality_constrained_nonneg_projection.sv =====
// ============================================================================
// equality_constrained_nonneg_projection
// Nonnegative projection of two vectors under an equality constraint.
// ============================================================================
// Loading takes one word per cycle. After the last word, one pass sums q,
// then each search round steps through pivot, partition over the store
// ports, product and decision. The divider then runs, and each result
// is read from the store read port and then shown at the output.
// Reset is synchronous, active low, and clears all control state.
`default_nettype none

module equality_constrained_nonneg_projection
    import ecnp_pkg::*;
#(
    parameter int unsigned MAX_A_LEN = MaxALenDefault,
    parameter int unsigned MAX_Q_LEN = MaxQLenDefault
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  t_in_word   i_in_data,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output t_out_word  o_out_data
);

    t_ctrl w_ctrl;
    t_stat w_stat;
    logic  w_out_busy;

    ecnp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last      (i_in_data.last_item),
        .i_out_busy  (w_out_busy),
        .i_stat      (w_stat),
        .o_in_stall  (o_in_stall),
        .o_ctrl      (w_ctrl)
    );

    ecnp_dp #(
        .MAX_A_LEN (MAX_A_LEN),
        .MAX_Q_LEN (MAX_Q_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_in        (i_in_data),
        .i_out_stall (i_out_stall),
        .o_stat      (w_stat),
        .o_out_busy  (w_out_busy),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data)
    );

endmodule

`default_nettype wire

// ===== tb/equality_constrained_nonneg_projection_tb.sv =====
// ============================================================================
// equality_constrained_nonneg_projection_tb
// Drives sets of a0 and q0 words into the projection block, predicts the
// threshold and the clamped results of each set, and checks every output word
// in order under random sender gaps and receiver stalls.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module equality_constrained_nonneg_projection_tb;
    import ecnp_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_data;

    equality_constrained_nonneg_projection u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    always #6 i_clk = ~i_clk;

    t_in_word  pending_words[$];
    t_out_word projected_words[$];
    longint    set_a[$];
    longint    set_qneg[$];
    int        gap_pct = 0;
    int        stall_pct = 0;
    int        hold_cycles = 0;
    bit        pause_send = 1'b0;
    int        mismatches = 0;
    int        words_sent = 0;
    int        words_seen = 0;
    int        sets_done = 0;

    function automatic longint clamp_value(longint v);
        if (v <= 0) return 0;
        if (v > 64'sd2147483647) return 64'sd2147483647;
        return v;
    endfunction

    // Threshold search by pivot partition, floor-rounded in Q16.16 units.
    function automatic longint threshold_rho();
        longint sa = 0, sq = 0, sall = 0, piv, dsa, dsq, df, num, den, quo;
        int ta = 0, tq = 0, na, nq, nga, nea, ngq;
        bit am[32], qm[32], ga[32], la[32], gq[32], lq[32];
        bit found, any;
        na = set_a.size();
        nq = set_qneg.size();
        for (int i = 0; i < nq; i++) sall += set_qneg[i];
        for (int i = 0; i < 32; i++) begin
            am[i] = (i < na);
            qm[i] = (i < nq);
        end
        any = (na + nq) > 0;
        while (any) begin
            found = 1'b0;
            piv = 0;
            dsa = 0; dsq = 0; nga = 0; nea = 0; ngq = 0;
            for (int i = 0; i < 32; i++)
                if (!found && am[i]) begin piv = set_a[i]; found = 1'b1; end
            for (int i = 0; i < 32; i++)
                if (!found && qm[i]) begin piv = set_qneg[i]; found = 1'b1; end
            for (int i = 0; i < 32; i++) begin
                ga[i] = 0; la[i] = 0; gq[i] = 0; lq[i] = 0;
                if (am[i]) begin
                    if (set_a[i] > piv) begin ga[i] = 1; nga++; dsa += set_a[i]; end
                    else if (set_a[i] < piv) la[i] = 1;
                    else begin dsa += set_a[i]; nea++; end
                end
                if (qm[i]) begin
                    if (set_qneg[i] > piv) begin gq[i] = 1; ngq++; dsq += set_qneg[i]; end
                    else if (set_qneg[i] < piv) lq[i] = 1;
                end
            end
            df = sa + dsa + (sall - sq - dsq) - longint'(ta + nga + nea) * piv
                 - longint'(nq - tq - ngq) * piv;
            any = 1'b0;
            for (int i = 0; i < 32; i++) begin
                if (df < 0) begin am[i] = la[i]; qm[i] = lq[i]; end
                else begin am[i] = ga[i]; qm[i] = gq[i]; end
                any |= am[i] | qm[i];
            end
            if (df < 0) begin
                sa += dsa; ta += nga + nea;
                sq += dsq; tq += ngq;
            end
        end
        num = sa + sall - sq;
        den = longint'(ta) + longint'(nq) - longint'(tq);
        if (den <= 0) return 0;
        quo = num / den;
        if ((num % den) != 0 && num < 0) quo--;
        return quo;
    endfunction

    // Called for every accepted word, in acceptance order.
    function automatic void absorb_word(t_in_word w);
        longint v, rho;
        int n;
        t_out_word r;
        v = longint'($signed(w.elem_value));
        if (!w.which_vector) begin
            if (set_a.size() < 32) set_a.push_back(v);
        end else if (set_qneg.size() < 32) begin
            set_qneg.push_back(-v);
        end
        if (!w.last_item) return;
        rho = threshold_rho();
        n = set_a.size() + set_qneg.size();
        for (int i = 0; i < set_a.size(); i++) begin
            r.out_vector = 1'b0;
            r.out_index = i[4:0];
            r.out_value = 31'(clamp_value(set_a[i] - rho));
            r.last_result = (set_qneg.size() == 0) && (i == set_a.size() - 1);
            projected_words.push_back(r);
        end
        for (int i = 0; i < set_qneg.size(); i++) begin
            r.out_vector = 1'b1;
            r.out_index = i[4:0];
            r.out_value = 31'(clamp_value(-set_qneg[i] + rho));
            r.last_result = (i == set_qneg.size() - 1);
            projected_words.push_back(r);
        end
        if (n > 0) sets_done++;
        set_a.delete();
        set_qneg.delete();
    endfunction

    function automatic logic [31:0] pick_value(int mode);
        case (mode)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(0, 20)) - 10) << 16;
            3: return $urandom();
            default: return 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
        endcase
    endfunction

    task automatic queue_set(int na, int nq, int mode);
        t_in_word w;
        int total, k, ia, iq;
        total = na + nq;
        ia = 0; iq = 0;
        for (k = 0; k < total; k++) begin
            if (iq >= nq || (ia < na && $urandom_range(0, 1) == 0)) begin
                w.which_vector = 1'b0; ia++;
            end else begin
                w.which_vector = 1'b1; iq++;
            end
            w.elem_value = pick_value(mode < 0 ? $urandom_range(0, 4) : mode);
            w.last_item = (k == total - 1);
            pending_words.push_back(w);
        end
    endtask

    // Driver: valid never looks at stall; the payload holds while stalled.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                absorb_word(i_in_data);
                words_sent++;
                void'(pending_words.pop_front());
            end
            if (i_in_valid && o_in_stall) begin
                i_in_valid <= 1'b1;
            end else if (pending_words.size() > 0 &&
                         !pause_send && $urandom_range(0, 99) >= gap_pct) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_words[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted down once per cycle.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // Receiver stall generation and result checking.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                words_seen++;
                if (projected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word %h", o_out_data);
                end else begin
                    if (o_out_data !== projected_words[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected vec %0d idx %0d val %h last %0d,",
                                      " got vec %0d idx %0d val %h last %0d"},
                                projected_words[0].out_vector, projected_words[0].out_index,
                                projected_words[0].out_value, projected_words[0].last_result,
                                o_out_data.out_vector, o_out_data.out_index,
                                o_out_data.out_value, o_out_data.last_result);
                    end
                    void'(projected_words.pop_front());
                end
            end
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    task automatic drain();
        while (pending_words.size() > 0 || i_in_valid) @(posedge i_clk);
        while (projected_words.size() > 0) @(posedge i_clk);
        repeat (2200) @(posedge i_clk);
    endtask

    task automatic random_phase(int count);
        int start;
        start = words_sent;
        while (words_sent - start < count) begin
            case ($urandom_range(0, 9))
                0: queue_set($urandom_range(0, 3), $urandom_range(0, 3), -1);
                1: queue_set(33, $urandom_range(0, 2), -1);
                default: queue_set($urandom_range(0, 5), $urandom_range(0, 5), -1);
            endcase
            while (pending_words.size() > 0 || i_in_valid) @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: extremes, single vectors, equal pivots and mixed sets.
        queue_set(1, 1, 0);
        queue_set(1, 1, 1);
        queue_set(2, 0, 2);
        queue_set(0, 2, 2);
        queue_set(2, 2, 3);
        queue_set(3, 3, 2);
        drain();
        gap_pct = 33; stall_pct = 85;
        random_phase(62);
        drain();
        // Long receiver hold-off while the sender keeps offering words.
        hold_cycles <= 1500;
        queue_set(6, 6, -1);
        queue_set(4, 4, -1);
        drain();
        pause_send = 1'b1;
        repeat (50) @(posedge i_clk);
        pause_send = 1'b0;
        gap_pct = 85; stall_pct = 33;
        random_phase(62);
        drain();
        gap_pct = 0; stall_pct = 0;
        random_phase(62);
        drain();
        $display("covered %0d input words, %0d result words, %0d nonempty sets",
                 words_sent, words_seen, sets_done);
        if (mismatches == 0 && projected_words.size() == 0) begin
            $display("equality_constrained_nonneg_projection_tb: clean");
        end else begin
            $display("equality_constrained_nonneg_projection_tb: errors");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("equality_constrained_nonneg_projection_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/ecnp_pkg.sv
sv/ecnp_ctrl.sv
sv/ecnp_div.sv
sv/ecnp_dp.sv
sv/equality_constrained_nonneg_projection.sv
tb/equality_constrained_nonneg_projection_tb.sv
